[hdl/sha1_block_hash_unit_assert.svh]
// Assertion macros for the SHA-1 block hash unit.
// Included by the top level; depends on nothing else.
`ifndef SHA1_BLOCK_HASH_UNIT_ASSERT_SVH
`define SHA1_BLOCK_HASH_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted
`define SHA1BH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define SHA1BH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sha1bh_pkg.sv]
// Shared types, constants and round functions of the SHA-1 block hash unit.
// Used by the controller, the datapath and the top level; no dependencies.
package sha1bh_pkg;

    localparam int WordWidth   = 32;
    localparam int BlockWords  = 16;
    localparam int NumRounds   = 80;
    localparam int DigestWords = 5;

    localparam int WcntWidth  = $clog2(BlockWords);
    localparam int RoundWidth = $clog2(NumRounds);
    localparam int OselWidth  = $clog2(DigestWords);

    typedef logic [WordWidth-1:0] t_word;

    // Round groups of twenty rounds each
    typedef enum logic [1:0] {
        GRP_CHOOSE = 2'd0,
        GRP_PARITY = 2'd1,
        GRP_MAJ    = 2'd2,
        GRP_PARITY2 = 2'd3
    } t_round_grp;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  load_word;
        logic                  init_work;
        logic                  round;
        logic                  expand;
        t_round_grp            grp;
        logic                  add_chain;
        logic                  reload_iv;
        logic [OselWidth-1:0]  out_sel;
    } t_dp_cmd;

    // Initial chaining value, H0 first
    function automatic t_word iv_word(input logic [OselWidth-1:0] idx);
        t_word w;
        case (idx)
            3'd0:    w = 32'h6745_2301;
            3'd1:    w = 32'hEFCD_AB89;
            3'd2:    w = 32'h98BA_DCFE;
            3'd3:    w = 32'h1032_5476;
            default: w = 32'hC3D2_E1F0;
        endcase
        return w;
    endfunction

    // Round constant of a group
    function automatic t_word round_k(input t_round_grp grp);
        t_word k;
        unique case (grp)
            GRP_CHOOSE:  k = 32'h5A82_7999;
            GRP_PARITY:  k = 32'h6ED9_EBA1;
            GRP_MAJ:     k = 32'h8F1B_BCDC;
            GRP_PARITY2: k = 32'hCA62_C1D6;
            default:     k = 32'hCA62_C1D6;
        endcase
        return k;
    endfunction

    // Boolean round function of a group
    function automatic t_word round_f(input t_round_grp grp, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        unique case (grp)
            GRP_CHOOSE: f = (b & c) | (~b & d);
            GRP_MAJ:    f = (b & c) | (b & d) | (c & d);
            default:    f = b ^ c ^ d;
        endcase
        return f;
    endfunction

    function automatic t_word rotl1(input t_word v);
        return {v[WordWidth-2:0], v[WordWidth-1]};
    endfunction

    function automatic t_word rotl5(input t_word v);
        return {v[WordWidth-6:0], v[WordWidth-1:WordWidth-5]};
    endfunction

    function automatic t_word rotl30(input t_word v);
        return {v[1:0], v[WordWidth-1:2]};
    endfunction

endpackage

[hdl/sha1bh_ctrl.sv]
// Control state machine of the SHA-1 block hash unit: word count, round
// count and digest readout sequencing. Depends on sha1bh_pkg.
module sha1bh_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_final,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output logic                  o_out_last,
    input  logic                  i_out_ready,
    output sha1bh_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INIT  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    localparam logic [sha1bh_pkg::WcntWidth-1:0] LastWord =
        sha1bh_pkg::WcntWidth'(sha1bh_pkg::BlockWords - 1);
    localparam logic [sha1bh_pkg::RoundWidth-1:0] LastRound =
        sha1bh_pkg::RoundWidth'(sha1bh_pkg::NumRounds - 1);
    localparam logic [sha1bh_pkg::OselWidth-1:0] LastOut =
        sha1bh_pkg::OselWidth'(sha1bh_pkg::DigestWords - 1);

    t_state                              r_state, n_state;
    logic [sha1bh_pkg::WcntWidth-1:0]    r_wcnt, n_wcnt;
    logic [sha1bh_pkg::RoundWidth-1:0]   r_round, n_round;
    logic [sha1bh_pkg::OselWidth-1:0]    r_osel, n_osel;
    logic                                r_final, n_final;
    logic                                r_pend, n_pend;
    logic                                in_hs, out_hs, blk_done;

    // Take words while idle, or while the digest drains and no block waits
    assign o_in_ready  = (r_state == ST_IDLE) || ((r_state == ST_EMIT) && !r_pend);
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_out_last  = (r_osel == LastOut);
    assign in_hs       = i_in_valid && o_in_ready;
    assign out_hs      = o_out_valid && i_out_ready;
    assign blk_done    = in_hs && (r_wcnt == LastWord);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_wcnt  = r_wcnt;
        n_round = r_round;
        n_osel  = r_osel;
        n_final = r_final;
        n_pend  = r_pend;

        o_cmd           = '0;
        o_cmd.load_word = in_hs;
        o_cmd.out_sel   = r_osel;
        o_cmd.expand    = (r_round >= sha1bh_pkg::RoundWidth'(sha1bh_pkg::BlockWords));
        if (r_round < sha1bh_pkg::RoundWidth'(20)) begin
            o_cmd.grp = sha1bh_pkg::GRP_CHOOSE;
        end else if (r_round < sha1bh_pkg::RoundWidth'(40)) begin
            o_cmd.grp = sha1bh_pkg::GRP_PARITY;
        end else if (r_round < sha1bh_pkg::RoundWidth'(60)) begin
            o_cmd.grp = sha1bh_pkg::GRP_MAJ;
        end else begin
            o_cmd.grp = sha1bh_pkg::GRP_PARITY2;
        end

        // Count words of the block; the sixteenth word's flag decides the digest
        if (in_hs) begin
            n_wcnt = r_wcnt + 1'b1;
            if (blk_done) begin
                n_final = i_in_final;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (blk_done) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                o_cmd.init_work = 1'b1;
                n_round         = '0;
                n_state         = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (r_round == LastRound) begin
                    n_round = '0;
                    n_state = ST_ADD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            ST_ADD: begin
                o_cmd.add_chain = 1'b1;
                n_osel          = '0;
                n_state         = r_final ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (blk_done) begin
                    n_pend = 1'b1;
                end
                if (out_hs) begin
                    if (r_osel == LastOut) begin
                        o_cmd.reload_iv = 1'b1;
                        n_pend          = 1'b0;
                        n_state         = (r_pend || blk_done) ? ST_INIT : ST_IDLE;
                    end else begin
                        n_osel = r_osel + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wcnt  <= '0;
            r_round <= '0;
            r_osel  <= '0;
            r_final <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wcnt  <= n_wcnt;
            r_round <= n_round;
            r_osel  <= n_osel;
            r_final <= n_final;
            r_pend  <= n_pend;
        end
    end

endmodule

[hdl/sha1bh_datapath.sv]
// Datapath of the SHA-1 block hash unit: schedule shift window, working
// variables, round unit and chaining value. Depends on sha1bh_pkg.
module sha1bh_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sha1bh_pkg::t_dp_cmd  i_cmd,
    input  sha1bh_pkg::t_word    i_word,
    output sha1bh_pkg::t_word    o_digest
);

    sha1bh_pkg::t_word r_win [sha1bh_pkg::BlockWords];
    sha1bh_pkg::t_word r_h   [sha1bh_pkg::DigestWords];
    sha1bh_pkg::t_word r_a, r_b, r_c, r_d, r_e;
    sha1bh_pkg::t_word w_new, w_cur, w_shift_in, tmp;

    // Schedule word of this round: stored for the first sixteen, expanded after
    assign w_new = sha1bh_pkg::rotl1(r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0]);
    assign w_cur = i_cmd.expand ? w_new : r_win[0];
    assign w_shift_in = i_cmd.round ? w_cur : i_word;

    // One round
    assign tmp = sha1bh_pkg::rotl5(r_a) + sha1bh_pkg::round_f(i_cmd.grp, r_b, r_c, r_d)
               + r_e + sha1bh_pkg::round_k(i_cmd.grp) + w_cur;

    // Shift the window on every incoming word and every round
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word || i_cmd.round) begin
            for (int i = 0; i < sha1bh_pkg::BlockWords - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[sha1bh_pkg::BlockWords-1] <= w_shift_in;
        end
    end

    // Working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_work) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round) begin
            r_a <= tmp;
            r_b <= r_a;
            r_c <= sha1bh_pkg::rotl30(r_b);
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    // Chaining value: reload on reset and after a digest, add the block result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reload_iv) begin
            for (int i = 0; i < sha1bh_pkg::DigestWords; i++) begin
                r_h[i] <= sha1bh_pkg::iv_word(sha1bh_pkg::OselWidth'(i));
            end
        end else if (i_cmd.add_chain) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    // Digest word select
    always_comb begin
        case (i_cmd.out_sel)
            3'd0:    o_digest = r_h[0];
            3'd1:    o_digest = r_h[1];
            3'd2:    o_digest = r_h[2];
            3'd3:    o_digest = r_h[3];
            default: o_digest = r_h[4];
        endcase
    end

endmodule

[hdl/sha1_block_hash_unit.sv]
// SHA-1 block hash unit. A block is taken in as 16 words, then compressed by a
// setup step, 80 rounds at one per cycle through the single round unit and a
// chaining add; no words are taken while a block is compressed.
// The digest of a final block is valid after its chaining add; its five words
// leave as the sink takes them, overlapped with input of the next block.
// Reset (synchronous, active low) reloads the initial value and clears counters.
module sha1_block_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] message_word
    input  logic        s_axis_tuser,   // [0] final_block
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast    // digest_last
);

    sha1bh_pkg::t_dp_cmd cmd;
    logic [3:0]          dp_steps;
    logic                port_busy;
    logic                last_out;

    // Sequencer
    sha1bh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_final  (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_last  (m_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    // Hash datapath
    sha1bh_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_word   (s_axis_tdata),
        .o_digest (m_axis_tdata)
    );

    // Terms watched by the checks below
    assign dp_steps  = {cmd.init_work, cmd.round, cmd.add_chain, cmd.reload_iv};
    assign port_busy = s_axis_tready || m_axis_tvalid;
    assign last_out  = m_axis_tvalid && m_axis_tready && m_axis_tlast;

`include "sha1_block_hash_unit_assert.svh"

    // Datapath steps never overlap one another
    `SHA1BH_ASSERT_NOW(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(dp_steps), "command overlap")
    // No word enters and no digest leaves while rounds run
    `SHA1BH_ASSERT_NOW(a_round_quiet, i_clk, i_rst_n, cmd.round, !port_busy, "busy port in rounds")
    // Digest ends after the fifth word is taken
    `SHA1BH_ASSERT_NEXT(a_digest_end, i_clk, i_rst_n, last_out, !m_axis_tvalid, "digest overrun")

endmodule

[test/tb.sv]
// Testbench for sha1_block_hash_unit: streams message blocks, predicts
// each digest in a local SHA-1 model and checks every digest word in order.
// Depends on sha1bh_pkg and the sha1_block_hash_unit RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int LONG_HOLD      = 600;

    // One expected digest beat
    typedef struct packed {
        logic              last;
        sha1bh_pkg::t_word word;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] message_word
    logic        s_axis_tuser = 1'b0;   // [0] final_block
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [31:0] digest_word
    logic        m_axis_tlast;          // digest_last

    // Local hash state: chaining value, current block, word position
    sha1bh_pkg::t_word chain_h [5];
    sha1bh_pkg::t_word block_w [16];
    int unsigned       word_pos;
    t_digest_beat      pending_digest_q [$];
    t_digest_beat      digest_head;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_len       = 0;
    logic        hold_go        = 1'b0;
    logic        hold_seen      = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned stall_cycles   = 0;
    int unsigned digest_errors  = 0;

    sha1_block_hash_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // SHA-1 prediction
    // ---------------------------------------------------------------
    function automatic sha1bh_pkg::t_word rol(input sha1bh_pkg::t_word v,
                                              input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void load_initial_hash();
        chain_h[0] = 32'h6745_2301;
        chain_h[1] = 32'hEFCD_AB89;
        chain_h[2] = 32'h98BA_DCFE;
        chain_h[3] = 32'h1032_5476;
        chain_h[4] = 32'hC3D2_E1F0;
    endfunction

    // Run 80 rounds over the buffered block and fold into the chaining value
    function automatic void compress_block_words();
        sha1bh_pkg::t_word      w [80];
        sha1bh_pkg::t_word      a, b, c, d, e, f, k, tmp;
        sha1bh_pkg::t_round_grp grp;
        for (int t = 0; t < 80; t++) begin
            if (t < 16)
                w[t] = block_w[t];
            else
                w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int t = 0; t < 80; t++) begin
            grp = sha1bh_pkg::t_round_grp'(t / 20);
            case (grp)
                sha1bh_pkg::GRP_CHOOSE: begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A82_7999;
                end
                sha1bh_pkg::GRP_PARITY: begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9_EBA1;
                end
                sha1bh_pkg::GRP_MAJ: begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1B_BCDC;
                end
                default: begin
                    f = b ^ c ^ d;
                    k = 32'hCA62_C1D6;
                end
            endcase
            tmp = rol(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rol(b, 30);
            b = a;
            a = tmp;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Absorb one accepted word; only the sixteenth word's flag matters
    function automatic void hash_absorb_word(input sha1bh_pkg::t_word word, input logic fin);
        t_digest_beat beat;
        block_w[word_pos] = word;
        if (word_pos != 15) begin
            word_pos++;
        end else begin
            word_pos = 0;
            compress_block_words();
            if (fin) begin
                for (int i = 0; i < 5; i++) begin
                    beat.word = chain_h[i];
                    beat.last = (i == 4);
                    pending_digest_q.push_back(beat);
                end
                load_initial_hash();
            end
        end
    endfunction

    function automatic sha1bh_pkg::t_word pick_word();
        sha1bh_pkg::t_word w;
        case ($urandom_range(7))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Sink side: random stalls plus an on-demand long hold
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen     <= hold_go;
            hold_left     <= hold_len;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Compare each accepted digest word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_digest_q.size() == 0) begin
                $error("unexpected digest word %h (last %b)", m_axis_tdata, m_axis_tlast);
                digest_errors = digest_errors + 1;
            end else begin
                digest_head = pending_digest_q.pop_front();
                if (m_axis_tdata !== digest_head.word) begin
                    $error("digest_word: expected %h, got %h", digest_head.word, m_axis_tdata);
                    digest_errors = digest_errors + 1;
                end
                if (m_axis_tlast !== digest_head.last) begin
                    $error("digest_last: expected %b, got %b", digest_head.last, m_axis_tlast);
                    digest_errors = digest_errors + 1;
                end
            end
        end
    end

    // Abort when no request moves on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** sha1_block_hash_unit: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Source side
    // ---------------------------------------------------------------
    // Offer one word, idling at random first, and predict it once accepted
    task automatic send_word(input sha1bh_pkg::t_word word, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        hash_absorb_word(word, fin);
    endtask

    // Send a well-formed message of random words; flags before word 16 are noise
    task automatic send_message(input int unsigned n_blocks);
        for (int unsigned b = 0; b < n_blocks; b++) begin
            for (int i = 0; i < 15; i++)
                send_word(pick_word(), 1'($urandom_range(1)));
            send_word(pick_word(), b == n_blocks - 1);
        end
    endtask

    // Drop valid and wait until every predicted digest word has come back
    task automatic wait_digests_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_digest_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // All-ones block with ignored flags and no digest, then an all-zero final block
    task automatic test_directed_blocks();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int i = 0; i < 15; i++)
            send_word('1, 1'b1);
        send_word('1, 1'b0);
        for (int i = 0; i < 15; i++)
            send_word('0, 1'b0);
        send_word('0, 1'b1);
        wait_digests_drained();
    endtask

    // Random messages until a block budget is spent, under one idling mix
    task automatic test_random_messages(input int unsigned src_pct,
                                        input int unsigned sink_pct,
                                        input int unsigned min_blocks);
        int unsigned sent;
        int unsigned n;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        sent = 0;
        while (sent < min_blocks) begin
            n = ($urandom_range(3) == 0) ? 3 : $urandom_range(1, 2);
            if (n > min_blocks - sent)
                n = min_blocks - sent;
            send_message(n);
            sent += n;
        end
        wait_digests_drained();
    endtask

    // Hold the sink off for a long stretch while single-block messages pile up
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_len       = LONG_HOLD;
        hold_go        = ~hold_go;
        for (int i = 0; i < 3; i++)
            send_message(1);
        wait_digests_drained();
    endtask

    initial begin
        load_initial_hash();
        word_pos = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_blocks();
        test_random_messages(0, 0, 4);
        test_random_messages(67, 0, 4);
        test_backpressure();
        test_random_messages(0, 67, 3);
        test_random_messages(34, 34, 3);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_digest_q.size() != 0) begin
            $error("%0d digest words never arrived", pending_digest_q.size());
            digest_errors = digest_errors + 1;
        end
        if (digest_errors == 0)
            $display("** sha1_block_hash_unit: PASSED **");
        else
            $display("** sha1_block_hash_unit: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/sha1bh_pkg.sv
hdl/sha1bh_ctrl.sv
hdl/sha1bh_datapath.sv
hdl/sha1_block_hash_unit.sv
test/tb.sv
